// ----- src/electronic_load_setpoint_engine_macros.svh -----
// Assertion macros shared by the setpoint engine RTL.
`ifndef ELECTRONIC_LOAD_SETPOINT_ENGINE_MACROS_SVH
`define ELECTRONIC_LOAD_SETPOINT_ENGINE_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define ELSPE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define ELSPE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/elspe_pkg.sv -----
// Types and constants of the electronic-load setpoint engine.
`default_nettype none
package elspe_pkg;

  // Command codes carried on the input tuser.
  typedef enum logic [2:0] {
    CMD_VOLT    = 3'd0,
    CMD_AMP     = 3'd1,
    CMD_SET_CUR = 3'd2,
    CMD_SET_RES = 3'd3,
    CMD_SET_PWR = 3'd4,
    CMD_ENABLE  = 3'd5,
    CMD_DISABLE = 3'd6,
    CMD_TICK    = 3'd7
  } cmd_t;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_MAX_CURRENT = 3'd0;
  localparam logic [2:0] REG_MAX_VOLTAGE = 3'd1;
  localparam logic [2:0] REG_MAX_POWER   = 3'd2;
  localparam logic [2:0] REG_MARGIN      = 3'd3;
  localparam logic [2:0] REG_ENFORCE     = 3'd4;

  // Register reset values.
  localparam logic [19:0] RST_MAX_CURRENT = 20'd10000;
  localparam logic [19:0] RST_MAX_VOLTAGE = 20'd60000;
  localparam logic [19:0] RST_MAX_POWER   = 20'd150000;
  localparam logic [9:0]  RST_MARGIN      = 10'd256;

  // Arithmetic constants.
  localparam logic [29:0] OHM_OPEN = 30'd1000000000;
  localparam logic [30:0] POW_MAX  = 31'h7FFFFFFF;
  localparam logic [9:0]  MILLI    = 10'd1000;
  localparam logic [19:0] MEGA     = 20'd1000000;

  // Datapath width of the shared serial unit and width of the divider step counter.
  localparam int DP_W     = 64;
  localparam int DIV_CNT_W = 6;

  // Main sequencer states.
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_DISP  = 9'b000000010,
    ST_SAMP  = 9'b000000100,
    ST_MUL   = 9'b000001000,
    ST_DIV   = 9'b000010000,
    ST_NEXT  = 9'b000100000,
    ST_CLIP  = 9'b001000000,
    ST_CLIP3 = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  // Where the sequencer continues after the serial unit finishes.
  typedef enum logic [8:0] {
    PH_RES       = 9'b000000001,
    PH_PWR_MUL   = 9'b000000010,
    PH_PWR_DIV   = 9'b000000100,
    PH_TICK_MUL  = 9'b000001000,
    PH_TICK_DIV  = 9'b000010000,
    PH_CUR       = 9'b000100000,
    PH_CLIP_MUL  = 9'b001000000,
    PH_CLIP_CMP  = 9'b010000000,
    PH_CLIP_PDIV = 9'b100000000
  } phase_t;

endpackage
`default_nettype wire

// ----- src/electronic_load_setpoint_engine.sv -----
// Electronic-load measurement and setpoint engine, top level.
//
//   Channel   Direction  Signals                        Content
//   s_*       in         tvalid tready tdata tuser      sample/setpoint value, command
//   m_*       out        tvalid tready tdata            DAC write, readings, energy
//   APB       in/out     psel penable pwrite paddr ...  limit and margin registers
//
// One item at a time. How long an item takes depends on the command and is set by
// the shared one-bit-per-cycle unit: a divide forms one quotient bit per cycle, a
// multiply handles one multiplier bit per cycle until the multiplier runs out of
// ones, and an item needs up to three divides. Reset is synchronous; there is no
// clearing pass. A stalled output holds the finished result while the next item
// is already accepted and computed.
`default_nettype none
`include "electronic_load_setpoint_engine_macros.svh"

module electronic_load_setpoint_engine #(
  parameter int VALUE_BITS = 20
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // Input stream.
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0]        s_tdata,  // value
  input  wire logic [2:0]                             s_tuser,  // command
  // Output stream.
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // dac_write, dac_value[20], applied, voltage[20], current[20],
  // resistance[30], power[31], energy[32], zero padding
  output logic [159:0]                                m_tdata,
  // Configuration port.
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [4:0]                             paddr,
  input  wire logic [31:0]                            pwdata,
  output logic [31:0]                                 prdata,
  output logic                                        pready
);
  import elspe_pkg::*;

  localparam logic [VALUE_BITS-1:0] VMAX = '1;

  // Configuration registers.
  logic [19:0] max_current;
  logic [19:0] max_voltage;
  logic [19:0] max_power;
  logic [9:0]  limit_margin;
  logic        enforce;

  // Stored state.
  logic [VALUE_BITS-1:0] volt;
  logic [VALUE_BITS-1:0] amp;
  logic [29:0]           ohm;
  logic [30:0]           watt;
  logic [31:0]           energy;
  logic                  output_on;

  // Sequencer and item registers.
  state_t                state;
  phase_t                phase;
  cmd_t                  cmd;
  logic [VALUE_BITS-1:0] val;
  logic                  wr;
  logic                  app;
  logic [DP_W-1:0]       cur;

  // Shared serial multiply/divide unit.
  logic [DP_W-1:0]      opx;
  logic [DP_W-1:0]      opy;
  logic [DP_W-1:0]      acc;
  logic [DIV_CNT_W-1:0] cnt;

  // Output payload registers.
  logic        out_write;
  logic [19:0] out_dac;
  logic        out_applied;
  logic [19:0] out_voltage;
  logic [19:0] out_current;
  logic [29:0] out_res;
  logic [30:0] out_power;
  logic [31:0] out_energy;

  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_MAX_CURRENT: prdata = 32'(max_current);
      REG_MAX_VOLTAGE: prdata = 32'(max_voltage);
      REG_MAX_POWER:   prdata = 32'(max_power);
      REG_MARGIN:      prdata = 32'(limit_margin);
      REG_ENFORCE:     prdata = 32'(enforce);
      default:         prdata = '0;
    endcase
  end

  // Limit thresholds: x*256 > L*m is the same as x > (L*m)>>8.
  logic [29:0] vlim_prod;
  logic [29:0] plim_prod;
  logic [29:0] clim_prod;
  assign vlim_prod = 30'(max_voltage) * 30'(limit_margin);
  assign plim_prod = 30'(max_power) * 30'(limit_margin);
  assign clim_prod = 30'(max_current) * 30'(limit_margin);

  // Operand scaling by the constant 1000.
  logic [DP_W-1:0] volt_k;
  logic [DP_W-1:0] val_k;
  logic [DP_W-1:0] pmax_k;
  assign volt_k = DP_W'(volt) * DP_W'(MILLI);
  assign val_k  = DP_W'(val) * DP_W'(MILLI);
  assign pmax_k = DP_W'(max_power) * DP_W'(MILLI);

  // One restoring divide step.
  logic [DP_W-1:0] rem_sh;
  assign rem_sh = {acc[DP_W-2:0], opx[DP_W-1]};

  // Current after the voltage check, the DAC saturation and the energy sum.
  logic [DP_W-1:0]       cur_vchk;
  logic [VALUE_BITS-1:0] dac_sat;
  logic [32:0]           energy_sum;
  assign cur_vchk   = (DP_W'(volt) > DP_W'(vlim_prod[29:8])) ? '0 : cur;
  assign dac_sat    = (cur > DP_W'(VMAX)) ? VMAX : cur[VALUE_BITS-1:0];
  assign energy_sum = {1'b0, energy} + {1'b0, opx[31:0]};

  assign s_tready = (state == ST_IDLE);

  // Sequencer, serial unit, state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= PH_RES;
      m_tvalid     <= 1'b0;
      max_current  <= RST_MAX_CURRENT;
      max_voltage  <= RST_MAX_VOLTAGE;
      max_power    <= RST_MAX_POWER;
      limit_margin <= RST_MARGIN;
      enforce      <= 1'b1;
      volt         <= '0;
      amp          <= '0;
      ohm          <= '0;
      watt         <= '0;
      energy       <= '0;
      output_on    <= 1'b0;
    end else begin
      // Output valid: set when a result is loaded, cleared once it is taken.
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_wr) begin
        case (reg_idx)
          REG_MAX_CURRENT: max_current  <= pwdata[19:0];
          REG_MAX_VOLTAGE: max_voltage  <= pwdata[19:0];
          REG_MAX_POWER:   max_power    <= pwdata[19:0];
          REG_MARGIN:      limit_margin <= pwdata[9:0];
          REG_ENFORCE:     enforce      <= pwdata[0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd   <= cmd_t'(s_tuser);
            val   <= s_tdata[VALUE_BITS-1:0];
            wr    <= 1'b0;
            app   <= 1'b0;
            cur   <= '0;
            state <= ST_DISP;
          end
        end

        // Decode the command.
        ST_DISP: begin
          case (cmd)
            CMD_VOLT: begin
              volt  <= val;
              state <= ST_SAMP;
            end
            CMD_AMP: begin
              amp   <= val;
              state <= ST_SAMP;
            end
            CMD_SET_CUR: begin
              if (output_on) begin
                wr    <= 1'b1;
                app   <= 1'b1;
                cur   <= DP_W'(val);
                state <= ST_CLIP;
              end else begin
                state <= ST_DONE;
              end
            end
            CMD_SET_RES: begin
              if (output_on && val != '0) begin
                wr    <= 1'b1;
                app   <= 1'b1;
                opx   <= volt_k;
                opy   <= DP_W'(val);
                acc   <= '0;
                cnt   <= '1;
                phase <= PH_CUR;
                state <= ST_DIV;
              end else begin
                wr    <= output_on;
                state <= ST_DONE;
              end
            end
            CMD_SET_PWR: begin
              if (output_on && volt != '0) begin
                wr    <= 1'b1;
                app   <= 1'b1;
                opx   <= val_k;
                opy   <= DP_W'(volt);
                acc   <= '0;
                cnt   <= '1;
                phase <= PH_CUR;
                state <= ST_DIV;
              end else begin
                wr    <= output_on;
                state <= ST_DONE;
              end
            end
            CMD_ENABLE: begin
              if (!output_on) begin
                energy <= '0;
              end
              output_on <= 1'b1;
              state     <= ST_DONE;
            end
            CMD_DISABLE: begin
              wr        <= output_on;
              output_on <= 1'b0;
              state     <= ST_DONE;
            end
            CMD_TICK: begin
              if (output_on) begin
                opx   <= DP_W'(amp);
                opy   <= DP_W'(volt);
                acc   <= '0;
                phase <= PH_TICK_MUL;
                state <= ST_MUL;
              end else begin
                state <= ST_DONE;
              end
            end
            default: state <= ST_DONE;
          endcase
        end

        // Recompute resistance, then power.
        ST_SAMP: begin
          if (amp != '0) begin
            opx   <= volt_k;
            opy   <= DP_W'(amp);
            acc   <= '0;
            cnt   <= '1;
            phase <= PH_RES;
            state <= ST_DIV;
          end else begin
            ohm   <= OHM_OPEN;
            opx   <= DP_W'(amp);
            opy   <= DP_W'(volt);
            acc   <= '0;
            phase <= PH_PWR_MUL;
            state <= ST_MUL;
          end
        end

        // Shift-and-add multiply, done when the multiplier runs out of ones.
        ST_MUL: begin
          if (opx == '0) begin
            opx   <= acc;
            state <= ST_NEXT;
          end else begin
            if (opx[0]) begin
              acc <= acc + opy;
            end
            opx <= opx >> 1;
            opy <= opy << 1;
          end
        end

        // Restoring divide, one quotient bit per cycle.
        ST_DIV: begin
          if (rem_sh >= opy) begin
            acc <= rem_sh - opy;
            opx <= {opx[DP_W-2:0], 1'b1};
          end else begin
            acc <= rem_sh;
            opx <= {opx[DP_W-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_NEXT;
          end
        end

        // Continue with the result in opx.
        ST_NEXT: begin
          case (phase)
            PH_RES: begin
              ohm   <= (opx > DP_W'(OHM_OPEN)) ? OHM_OPEN : opx[29:0];
              opx   <= DP_W'(amp);
              opy   <= DP_W'(volt);
              acc   <= '0;
              phase <= PH_PWR_MUL;
              state <= ST_MUL;
            end
            PH_PWR_MUL: begin
              opy   <= DP_W'(MILLI);
              acc   <= '0;
              cnt   <= '1;
              phase <= PH_PWR_DIV;
              state <= ST_DIV;
            end
            PH_PWR_DIV: begin
              watt  <= (opx > DP_W'(POW_MAX)) ? POW_MAX : opx[30:0];
              state <= ST_DONE;
            end
            PH_TICK_MUL: begin
              opy   <= DP_W'(MEGA);
              acc   <= '0;
              cnt   <= '1;
              phase <= PH_TICK_DIV;
              state <= ST_DIV;
            end
            PH_TICK_DIV: begin
              energy <= energy_sum[32] ? '1 : energy_sum[31:0];
              state  <= ST_DONE;
            end
            PH_CUR: begin
              cur   <= opx;
              state <= ST_CLIP;
            end
            PH_CLIP_MUL: begin
              opy   <= DP_W'(MILLI);
              acc   <= '0;
              cnt   <= '1;
              phase <= PH_CLIP_CMP;
              state <= ST_DIV;
            end
            PH_CLIP_CMP: begin
              if (opx > DP_W'(plim_prod[29:8])) begin
                if (volt != '0) begin
                  opx   <= pmax_k;
                  opy   <= DP_W'(volt);
                  acc   <= '0;
                  cnt   <= '1;
                  phase <= PH_CLIP_PDIV;
                  state <= ST_DIV;
                end else begin
                  cur   <= '0;
                  state <= ST_CLIP3;
                end
              end else begin
                state <= ST_CLIP3;
              end
            end
            PH_CLIP_PDIV: begin
              cur   <= opx;
              state <= ST_CLIP3;
            end
            default: state <= ST_DONE;
          endcase
        end

        // If enforced, voltage then serial-unit power check; else current cap.
        ST_CLIP: begin
          if (enforce) begin
            cur   <= cur_vchk;
            opx   <= DP_W'(volt);
            opy   <= cur_vchk;
            acc   <= '0;
            phase <= PH_CLIP_MUL;
            state <= ST_MUL;
          end else begin
            if (cmd != CMD_SET_CUR && cur > DP_W'(max_current)) begin
              cur <= DP_W'(max_current);
            end
            state <= ST_DONE;
          end
        end

        // Current limit check.
        ST_CLIP3: begin
          if (cur > DP_W'(clim_prod[29:8])) begin
            cur <= DP_W'(max_current);
          end
          state <= ST_DONE;
        end

        // Hand the result to the output register once it is free.
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            out_write   <= wr;
            out_dac     <= 20'(dac_sat);
            out_applied <= app;
            out_voltage <= 20'(volt);
            out_current <= 20'(amp);
            out_res     <= ohm;
            out_power   <= watt;
            out_energy  <= energy;
            state       <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {5'b0, out_energy, out_power, out_res, out_current, out_voltage,
                    out_applied, out_dac, out_write};

  // Checks on the sequencer and datapath.
  `ELSPE_ASSERT_IMP(a_dac_zero_no_write, m_tvalid && !out_write, out_dac == '0, "stray DAC value")
  `ELSPE_ASSERT_IMP(a_applied_has_write, m_tvalid && out_applied, out_write, "applied, no write")
  `ELSPE_ASSERT_IMP(a_ohm_range, 1'b1, ohm <= OHM_OPEN, "resistance above open-circuit value")
  `ELSPE_ASSERT_NXT(a_energy_monotonic, state != ST_DISP, energy >= $past(energy), "energy fell")

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the electronic-load setpoint engine.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import elspe_pkg::*;

  localparam logic [31:0] ADDR_MAX_CURRENT = 32'd0;
  localparam logic [31:0] ADDR_MAX_VOLTAGE = 32'd4;
  localparam logic [31:0] ADDR_MAX_POWER   = 32'd8;
  localparam logic [31:0] ADDR_MARGIN      = 32'd12;
  localparam logic [31:0] ADDR_ENFORCE     = 32'd16;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;

  // One result of the block, as carried on the output tdata.
  typedef struct packed {
    logic [31:0] energy;
    logic [30:0] power;
    logic [29:0] resistance;
    logic [19:0] current;
    logic [19:0] voltage;
    logic        applied;
    logic [19:0] dac_value;
    logic        dac_write;
  } reading_t;

  // One row of the directed table; chk_dac marks a typed-in DAC value.
  typedef struct {
    cmd_t        cmd;
    logic [19:0] value;
    bit          chk_dac;
    logic        dac_write;
    logic [19:0] dac_value;
    logic        applied;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [159:0] m_tdata;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  electronic_load_setpoint_engine u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the limit registers and the measurement state.
  logic [19:0] lim_cur, lim_volt, lim_pwr;
  logic [9:0]  lim_margin;
  logic        lim_on;
  logic [19:0] volt_rd, amp_rd;
  logic [29:0] ohm_rd;
  logic [30:0] watt_rd;
  logic [31:0] energy_acc;
  logic        load_on;

  reading_t expected_q[$];
  step_row_t typed_q[$];
  int  errors = 0;
  int  n_results = 0;
  int  idle_cycles = 0;
  bit  stall_hold = 1'b0;
  bit  long_stall_req = 1'b0;
  int  n_writes = 0;
  int  n_applied = 0;

  function automatic void reset_model();
    lim_cur = RST_MAX_CURRENT; lim_volt = RST_MAX_VOLTAGE;
    lim_pwr = RST_MAX_POWER; lim_margin = RST_MARGIN; lim_on = 1'b1;
    volt_rd = '0; amp_rd = '0; ohm_rd = '0; watt_rd = '0; energy_acc = '0;
    load_on = 1'b0;
  endfunction

  // Resistance and power from the latest readings.
  function automatic void derive_readings();
    logic [63:0] r, p;
    if (amp_rd != 0) begin
      r = 64'(volt_rd) * 1000 / amp_rd;
      if (r > 64'd1000000000) r = 64'd1000000000;
    end else begin
      r = 64'd1000000000;
    end
    p = 64'(volt_rd) * amp_rd / 1000;
    if (p > 64'h7FFFFFFF) p = 64'h7FFFFFFF;
    ohm_rd = r[29:0];
    watt_rd = p[30:0];
  endfunction

  // Drive current after the voltage, power and current limits.
  function automatic logic [63:0] limit_drive(logic [63:0] cur, bit cc_mode);
    logic [63:0] v, m;
    v = 64'(volt_rd);
    m = 64'(lim_margin);
    if (!lim_on) begin
      if (!cc_mode && cur > lim_cur) return 64'(lim_cur);
      return cur;
    end
    if (v * 256 > 64'(lim_volt) * m) cur = 0;
    if ((cur * v / 1000) * 256 > 64'(lim_pwr) * m)
      cur = (v > 0) ? 64'(lim_pwr) * 1000 / v : 64'd0;
    if (cur * 256 > 64'(lim_cur) * m) cur = 64'(lim_cur);
    return cur;
  endfunction

  function automatic reading_t predict_step(cmd_t cmd, logic [19:0] value);
    reading_t res;
    logic [63:0] dac, inc, e;
    res = '0;
    dac = 0;
    case (cmd)
      CMD_VOLT: begin
        volt_rd = value;
        derive_readings();
      end
      CMD_AMP: begin
        amp_rd = value;
        derive_readings();
      end
      CMD_SET_CUR: if (load_on) begin
        dac = limit_drive(64'(value), 1'b1);
        res.dac_write = 1'b1; res.applied = 1'b1;
      end
      CMD_SET_RES: if (load_on) begin
        res.dac_write = 1'b1;
        if (value != 0) begin
          dac = limit_drive(64'(volt_rd) * 1000 / value, 1'b0);
          res.applied = 1'b1;
        end
      end
      CMD_SET_PWR: if (load_on) begin
        res.dac_write = 1'b1;
        if (volt_rd != 0) begin
          dac = limit_drive(64'(value) * 1000 / volt_rd, 1'b0);
          res.applied = 1'b1;
        end
      end
      CMD_ENABLE: begin
        if (!load_on) energy_acc = '0;
        load_on = 1'b1;
      end
      CMD_DISABLE: begin
        if (load_on) res.dac_write = 1'b1;
        load_on = 1'b0;
      end
      default: if (load_on) begin
        inc = (64'(volt_rd) * amp_rd / 1000) / 1000;
        e = 64'(energy_acc) + inc;
        if (e > 64'hFFFFFFFF) e = 64'hFFFFFFFF;
        energy_acc = e[31:0];
      end
    endcase
    if (dac > 64'hFFFFF) dac = 64'hFFFFF;
    res.dac_value = dac[19:0];
    res.voltage = volt_rd;
    res.current = amp_rd;
    res.resistance = ohm_rd;
    res.power = watt_rd;
    res.energy = energy_acc;
    return res;
  endfunction

  // Random gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // Send one command and queue its predicted result; valid stays up until
  // the next command or a gap replaces it.
  task automatic send_cmd(cmd_t cmd, logic [19:0] value);
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {4'b0, value};
    expected_q.push_back(predict_step(cmd, value));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_with_gap(cmd_t cmd, logic [19:0] value);
    int g;
    g = pick_gap();
    if (g != 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    send_cmd(cmd, value);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write over the configuration port; only called while idle.
  task automatic write_reg(logic [31:0] addr, logic [31:0] data);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr[4:0]; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (addr)
      ADDR_MAX_CURRENT: lim_cur = data[19:0];
      ADDR_MAX_VOLTAGE: lim_volt = data[19:0];
      ADDR_MAX_POWER:   lim_pwr = data[19:0];
      ADDR_MARGIN:      lim_margin = data[9:0];
      ADDR_ENFORCE:     lim_on = data[0];
      default: ;
    endcase
  endtask

  task automatic set_limits(logic [19:0] c, logic [19:0] v, logic [19:0] p,
                            logic [9:0] m, logic e);
    write_reg(ADDR_MAX_CURRENT, 32'(c));
    write_reg(ADDR_MAX_VOLTAGE, 32'(v));
    write_reg(ADDR_MAX_POWER, 32'(p));
    write_reg(ADDR_MARGIN, 32'(m));
    write_reg(ADDR_ENFORCE, 32'(e));
  endtask

  function automatic logic [19:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 20'($urandom_range(0, 3));
      1: return 20'hFFFFF - 20'($urandom_range(0, 3));
      2: return 20'($urandom_range(0, 20000));
      3: return 20'($urandom_range(0, 200000));
      default: return 20'($urandom);
    endcase
  endfunction

  // Mostly a well-formed session: enable, samples, setpoints, ticks, disable.
  task automatic random_session(int n);
    int k;
    cmd_t c;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 15))
        0, 1:   c = CMD_VOLT;
        2, 3:   c = CMD_AMP;
        4, 5:   c = CMD_SET_CUR;
        6, 7:   c = CMD_SET_RES;
        8, 9:   c = CMD_SET_PWR;
        10:     c = CMD_ENABLE;
        11:     c = CMD_DISABLE;
        default: c = CMD_TICK;
      endcase
      if (k == 0) c = CMD_ENABLE;
      send_with_gap(c, rand_value());
    end
  endtask

  // Directed table: extremes, each command and the special cases.
  step_row_t dir_tab[] = '{
    '{CMD_SET_CUR, 20'd500,    1'b1, 1'b0, 20'd0, 1'b0},  // setpoint while disabled
    '{CMD_DISABLE, 20'd0,      1'b1, 1'b0, 20'd0, 1'b0},  // disable while off
    '{CMD_TICK,    20'd0,      1'b1, 1'b0, 20'd0, 1'b0},  // tick while off
    '{CMD_VOLT,    20'd12000,  1'b0, 1'b0, 20'd0, 1'b0},
    '{CMD_AMP,     20'd0,      1'b0, 1'b0, 20'd0, 1'b0},  // open-circuit resistance
    '{CMD_AMP,     20'd2500,   1'b0, 1'b0, 20'd0, 1'b0},
    '{CMD_ENABLE,  20'hFFFFF,  1'b1, 1'b0, 20'd0, 1'b0},
    '{CMD_SET_CUR, 20'd3000,   1'b0, 1'b0, 20'd0, 1'b0},
    '{CMD_SET_CUR, 20'hFFFFF,  1'b0, 1'b0, 20'd0, 1'b0},  // above current limit
    '{CMD_SET_RES, 20'd0,      1'b1, 1'b1, 20'd0, 1'b0},  // zero resistance
    '{CMD_SET_RES, 20'd4000,   1'b0, 1'b0, 20'd0, 1'b0},
    '{CMD_SET_RES, 20'd1,      1'b0, 1'b0, 20'd0, 1'b0},
    '{CMD_SET_PWR, 20'd30000,  1'b0, 1'b0, 20'd0, 1'b0},
    '{CMD_SET_PWR, 20'hFFFFF,  1'b0, 1'b0, 20'd0, 1'b0},  // above power limit
    '{CMD_TICK,    20'd0,      1'b0, 1'b0, 20'd0, 1'b0},
    '{CMD_VOLT,    20'hFFFFF,  1'b0, 1'b0, 20'd0, 1'b0},  // above voltage limit
    '{CMD_AMP,     20'hFFFFF,  1'b0, 1'b0, 20'd0, 1'b0},  // full-scale current reading
    '{CMD_SET_CUR, 20'd100,    1'b0, 1'b0, 20'd0, 1'b0},
    '{CMD_TICK,    20'd0,      1'b0, 1'b0, 20'd0, 1'b0},
    '{CMD_ENABLE,  20'd0,      1'b0, 1'b0, 20'd0, 1'b0},  // enable while on keeps energy
    '{CMD_VOLT,    20'd0,      1'b0, 1'b0, 20'd0, 1'b0},
    '{CMD_SET_PWR, 20'd5000,   1'b1, 1'b1, 20'd0, 1'b0},  // power at zero voltage
    '{CMD_DISABLE, 20'd0,      1'b1, 1'b1, 20'd0, 1'b0},
    '{CMD_DISABLE, 20'd0,      1'b1, 1'b0, 20'd0, 1'b0}
  };

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int g, k;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_stall_req) begin
        m_tready <= 1'b0;
        stall_hold = 1'b1;
        for (k = 0; k < 3000; k++) @(negedge clk);
        long_stall_req = 1'b0;
        stall_hold = 1'b0;
      end
      g = ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
      if (g != 0) begin
        m_tready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  // Result checker and inactivity watchdog.
  always @(posedge clk) begin
    reading_t got, want;
    step_row_t tr;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else if (!stall_hold) idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        got = reading_t'(m_tdata[154:0]);
        n_results++;
        if (got.dac_write) n_writes++;
        if (got.applied) n_applied++;
        if (expected_q.size() == 0) begin
          $error("unexpected result %h", m_tdata);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (typed_q.size() != 0) begin
            tr = typed_q.pop_front();
            if (tr.chk_dac && (tr.dac_write != got.dac_write ||
                tr.dac_value != got.dac_value || tr.applied != got.applied)) begin
              $error("typed row: dac_write/dac_value/applied exp %0d/%0d/%0d got %0d/%0d/%0d",
                     tr.dac_write, tr.dac_value, tr.applied,
                     got.dac_write, got.dac_value, got.applied);
              errors++;
            end
          end
          if (got.dac_write != want.dac_write) begin
            $error("dac_write exp %0d got %0d", want.dac_write, got.dac_write); errors++;
          end
          if (got.dac_value != want.dac_value) begin
            $error("dac_value exp %0d got %0d", want.dac_value, got.dac_value); errors++;
          end
          if (got.applied != want.applied) begin
            $error("applied exp %0d got %0d", want.applied, got.applied); errors++;
          end
          if (got.voltage != want.voltage) begin
            $error("voltage exp %0d got %0d", want.voltage, got.voltage); errors++;
          end
          if (got.current != want.current) begin
            $error("current exp %0d got %0d", want.current, got.current); errors++;
          end
          if (got.resistance != want.resistance) begin
            $error("resistance exp %0d got %0d", want.resistance, got.resistance);
            errors++;
          end
          if (got.power != want.power) begin
            $error("power exp %0d got %0d", want.power, got.power); errors++;
          end
          if (got.energy != want.energy) begin
            $error("energy exp %0d got %0d", want.energy, got.energy); errors++;
          end
        end
      end
    end
  end

  // Main stimulus sequence.
  initial begin
    int i, ph;
    reset_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under the reset limits.
    for (i = 0; i < dir_tab.size(); i++) begin
      typed_q.push_back(dir_tab[i]);
      send_with_gap(dir_tab[i].cmd, dir_tab[i].value);
    end
    wait_drained();

    // Full-scale readings and back-to-back ticks, enforcement off.
    set_limits(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 10'h3FF, 1'b0);
    send_cmd(CMD_VOLT, 20'hFFFFF);
    send_cmd(CMD_AMP, 20'hFFFFF);
    send_cmd(CMD_ENABLE, 20'd0);
    for (i = 0; i < 12; i++) send_cmd(CMD_TICK, 20'd0);
    send_cmd(CMD_SET_CUR, 20'hFFFFF);
    send_cmd(CMD_SET_RES, 20'd1);
    send_cmd(CMD_SET_PWR, 20'hFFFFF);
    send_cmd(CMD_DISABLE, 20'd0);
    wait_drained();

    // Random phases, each under its own register setting.
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_limits(RST_MAX_CURRENT, RST_MAX_VOLTAGE, RST_MAX_POWER, RST_MARGIN, 1'b1);
        1: set_limits(20'd0, 20'd0, 20'd0, 10'd0, 1'b1);
        2: set_limits(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 10'h3FF, 1'b1);
        3: set_limits(20'd5000, 20'd30000, 20'd50000, 10'd200, 1'b0);
        default: set_limits(20'($urandom), 20'($urandom), 20'($urandom),
                            10'($urandom), 1'($urandom));
      endcase
      if (ph == 2) long_stall_req = 1'b1;
      random_session(240);
      wait_drained();
    end

    $display("Covered %0d results: %0d DAC writes, %0d applied setpoints,",
             n_results, n_writes, n_applied);
    $display("directed edge cases, 8 limit settings, full-scale readings and stalls.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+src
src/elspe_pkg.sv
src/electronic_load_setpoint_engine.sv
tb/sv/testbench.sv
